// ----- rtl/bcd_pkg.sv -----
// Shared types, format codes and constant-divide helpers for the BC1/BC2/BC3 decoder.
// No dependencies; imported by every module of the decoder.
`default_nettype none

package bcd_pkg;

  // Format register codes
  localparam logic [1:0] FMT_BC1 = 2'd0;
  localparam logic [1:0] FMT_BC2 = 2'd1;
  localparam logic [1:0] FMT_BC3 = 2'd2;

  localparam int unsigned TEXEL_W = 32;
  localparam int unsigned ROWS    = 4;
  localparam int unsigned COLS    = 4;

  typedef logic [TEXEL_W-1:0]         texel_t;
  typedef logic [3:0][TEXEL_W-1:0]    pal_t;    // four packed RGBA palette entries
  typedef logic [7:0][7:0]            ramp_t;   // eight-entry BC3 alpha ramp
  typedef logic [COLS-1:0][TEXEL_W-1:0] row_t;  // one decoded row

  // floor(x/3) for x < 768: reciprocal 683/2048
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [19:0] p;
    p = {10'd0, x} * 20'd683;
    return p[18:11];
  endfunction

  // floor(x/7) for x < 1792: reciprocal 2341/16384
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [22:0] p;
    p = {12'd0, x} * 23'd2341;
    return p[21:14];
  endfunction

  // floor(x/5) for x < 1280: reciprocal 3277/16384
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [22:0] p;
    p = {12'd0, x} * 23'd3277;
    return p[21:14];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/bc1_bc2_bc3_block_decoder.sv -----
// Top level of the BC1/BC2/BC3 4x4 block decoder: handshake, pipeline registers, row counter.
// Depends on bcd_pkg, bcd_color_pal, bcd_alpha_ramp and bcd_row_sel.
`default_nettype none

// Channel   Dir  Handshake              Payload
// in_       in   in_valid / in_ready    in_block_low[63:0], in_block_high[63:0]
// out_      out  out_valid / out_ready  out_texel_col0..3[31:0], out_row_index[1:0],
//                                       out_last_row
// cfg_      in   cfg_wr_en (no wait)    cfg_wr_data[1:0] -> format register
//
// Three register stages: input register, decoded block register (palette, alpha
// ramp, index words), output register. One transaction in gives four out, top row
// first, one per cycle while out_ready stays high, so the output port sets the block rate.
// Row 0 moves from the input register through the decoded block register into the
// output register, and is taken when out_valid and out_ready are both high.
// The input register takes the next block while the current one is emitted;
// out_ready low stalls the output register and backs up into the stages behind it.
// Reset (rst_n, synchronous, active low) clears the valid flags and sets the
// format to BC1.

module bc1_bc2_bc3_block_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] in_block_low,
  input  wire logic [63:0] in_block_high,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_texel_col0,
  output logic [31:0]      out_texel_col1,
  output logic [31:0]      out_texel_col2,
  output logic [31:0]      out_texel_col3,
  output logic [1:0]       out_row_index,
  output logic             out_last_row
);
  import bcd_pkg::*;

  logic [1:0]  fmt_r;

  // input register
  logic        in_vld_r;
  logic [63:0] in_lo_r, in_hi_r;
  logic [1:0]  in_fmt_r;

  // decoded block register
  logic        blk_vld_r;
  logic [1:0]  blk_fmt_r;
  logic [1:0]  row_r;
  pal_t        blk_pal_r;
  ramp_t       blk_ramp_r;
  logic [31:0] blk_idx_r;
  logic [63:0] blk_alpha_r;

  // output register
  logic        out_vld_r;
  row_t        out_texels_r;
  logic [1:0]  out_row_r;
  logic        out_last_r;

  logic        out_load, blk_done, blk_load, in_fire;
  logic [63:0] color_word;
  pal_t        pal_nxt;
  ramp_t       ramp_nxt;
  row_t        row_nxt;

  assign out_load = blk_vld_r && (!out_vld_r || out_ready);
  assign blk_done = out_load && (row_r == 2'(ROWS - 1));
  assign blk_load = in_vld_r && (!blk_vld_r || blk_done);
  assign in_ready = !in_vld_r || blk_load;
  assign in_fire  = in_valid && in_ready;

  // BC1 carries color in the low word; BC2/BC3 in the high word
  assign color_word = (in_fmt_r == FMT_BC1) ? in_lo_r : in_hi_r;

  bcd_color_pal u_color_pal (
    .c0    (color_word[15:0]),
    .c1    (color_word[31:16]),
    .punch (in_fmt_r == FMT_BC1),
    .pal   (pal_nxt)
  );

  bcd_alpha_ramp u_alpha_ramp (
    .a0   (in_lo_r[7:0]),
    .a1   (in_lo_r[15:8]),
    .ramp (ramp_nxt)
  );

  bcd_row_sel u_row_sel (
    .fmt        (blk_fmt_r),
    .row        (row_r),
    .pal        (blk_pal_r),
    .ramp       (blk_ramp_r),
    .color_idx  (blk_idx_r),
    .alpha_word (blk_alpha_r),
    .texels     (row_nxt)
  );

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r     <= FMT_BC1;
      in_vld_r  <= 1'b0;
      blk_vld_r <= 1'b0;
      row_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        fmt_r <= cfg_wr_data;
      end
      if (in_fire) begin
        in_vld_r <= 1'b1;
      end else if (blk_load) begin
        in_vld_r <= 1'b0;
      end
      if (blk_load) begin
        blk_vld_r <= 1'b1;
        row_r     <= '0;
      end else if (blk_done) begin
        blk_vld_r <= 1'b0;
      end else if (out_load) begin
        row_r <= row_r + 2'd1;
      end
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_lo_r  <= in_block_low;
      in_hi_r  <= in_block_high;
      in_fmt_r <= fmt_r;
    end
    if (blk_load) begin
      blk_fmt_r   <= in_fmt_r;
      blk_pal_r   <= pal_nxt;
      blk_ramp_r  <= ramp_nxt;
      blk_idx_r   <= color_word[63:32];
      blk_alpha_r <= in_lo_r;
    end
    if (out_load) begin
      out_texels_r <= row_nxt;
      out_row_r    <= row_r;
      out_last_r   <= (row_r == 2'(ROWS - 1));
    end
  end

  assign out_valid      = out_vld_r;
  assign out_texel_col0 = out_texels_r[0];
  assign out_texel_col1 = out_texels_r[1];
  assign out_texel_col2 = out_texels_r[2];
  assign out_texel_col3 = out_texels_r[3];
  assign out_row_index  = out_row_r;
  assign out_last_row   = out_last_r;

endmodule

`default_nettype wire

// ----- rtl/bcd_color_pal.sv -----
// Color palette builder: two RGB565 endpoints to four RGBA8 entries.
// Depends on bcd_pkg (pal_t, div3).
`default_nettype none

module bcd_color_pal (
  input  wire logic [15:0]   c0,
  input  wire logic [15:0]   c1,
  input  wire logic          punch,   // BC1 rules: three-color mode when c0 <= c1
  output bcd_pkg::pal_t      pal
);
  import bcd_pkg::*;

  logic [2:0][7:0] e0, e1, mix2, mix3, half;
  logic [8:0]      sum [3];
  logic            four_color;

  always_comb begin
    // 565 -> 888 by bit replication; channel 0 R, 1 G, 2 B
    e0[0] = {c0[15:11], c0[15:13]};
    e0[1] = {c0[10:5],  c0[10:9]};
    e0[2] = {c0[4:0],   c0[4:2]};
    e1[0] = {c1[15:11], c1[15:13]};
    e1[1] = {c1[10:5],  c1[10:9]};
    e1[2] = {c1[4:0],   c1[4:2]};
    for (int k = 0; k < 3; k++) begin
      mix2[k] = div3(10'({e0[k], 1'b0}) + 10'(e1[k]));
      mix3[k] = div3(10'(e0[k]) + 10'({e1[k], 1'b0}));
      sum[k]  = 9'(e0[k]) + 9'(e1[k]);
      half[k] = sum[k][8:1];
    end
    four_color = (c0 > c1) || !punch;
    pal[0] = {8'hFF, e0[2], e0[1], e0[0]};
    pal[1] = {8'hFF, e1[2], e1[1], e1[0]};
    if (four_color) begin
      pal[2] = {8'hFF, mix2[2], mix2[1], mix2[0]};
      pal[3] = {8'hFF, mix3[2], mix3[1], mix3[0]};
    end else begin
      pal[2] = {8'hFF, half[2], half[1], half[0]};
      pal[3] = '0;  // transparent black
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bcd_alpha_ramp.sv -----
// BC3 alpha ramp builder: two 8-bit endpoints to an eight-entry ramp.
// Depends on bcd_pkg (ramp_t, div7, div5).
`default_nettype none

module bcd_alpha_ramp (
  input  wire logic [7:0] a0,
  input  wire logic [7:0] a1,
  output bcd_pkg::ramp_t  ramp
);
  import bcd_pkg::*;

  logic [7:0] step7 [1:6];
  logic [7:0] step5 [1:4];

  always_comb begin
    for (int i = 1; i <= 6; i++) begin
      step7[i] = div7(11'({3'd0, a0} * 11'(7 - i)) + 11'({3'd0, a1} * 11'(i)));
    end
    for (int i = 1; i <= 4; i++) begin
      step5[i] = div5(11'({3'd0, a0} * 11'(5 - i)) + 11'({3'd0, a1} * 11'(i)));
    end
    ramp[0] = a0;
    ramp[1] = a1;
    if (a0 > a1) begin
      for (int i = 1; i <= 6; i++) begin
        ramp[i+1] = step7[i];
      end
    end else begin
      for (int i = 1; i <= 4; i++) begin
        ramp[i+1] = step5[i];
      end
      ramp[6] = 8'h00;
      ramp[7] = 8'hFF;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bcd_row_sel.sv -----
// Row picker: selects palette entries and alpha for the four texels of one row.
// Depends on bcd_pkg (pal_t, ramp_t, row_t, format codes).
`default_nettype none

module bcd_row_sel (
  input  wire logic [1:0]   fmt,
  input  wire logic [1:0]   row,
  input  bcd_pkg::pal_t     pal,
  input  bcd_pkg::ramp_t    ramp,
  input  wire logic [31:0]  color_idx,
  input  wire logic [63:0]  alpha_word,
  output bcd_pkg::row_t     texels
);
  import bcd_pkg::*;

  logic [3:0] t     [COLS];
  logic [1:0] cidx  [COLS];
  logic [3:0] nib   [COLS];
  logic [5:0] aoff  [COLS];
  logic [2:0] aidx  [COLS];
  texel_t     base  [COLS];

  always_comb begin
    for (int c = 0; c < COLS; c++) begin
      t[c]    = {row, 2'(c)};
      cidx[c] = color_idx[{t[c], 1'b0} +: 2];
      nib[c]  = alpha_word[{t[c], 2'b00} +: 4];
      aoff[c] = 6'd16 + 6'(t[c]) * 6'd3;
      aidx[c] = alpha_word[aoff[c] +: 3];
      base[c] = pal[cidx[c]];
      unique case (fmt)
        FMT_BC1: texels[c] = base[c];
        FMT_BC2: texels[c] = {nib[c], nib[c], base[c][23:0]};
        FMT_BC3: texels[c] = {ramp[aidx[c]], base[c][23:0]};
        default: texels[c] = '0;  // unused code: transparent black
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- bench/tb_texel_pkg.sv -----
// Scoreboard for the BC1/BC2/BC3 block decoder bench: row prediction and row checking.
// Depends on bcd_pkg (format codes, texel and row types).
package tb_texel_pkg;
  import bcd_pkg::*;

  localparam logic [1:0] FMT_UNUSED = 2'd3;

  typedef struct packed {
    row_t       texels;   // texels[0] is column 0
    logic [1:0] row_idx;
    logic       last_row;
  } texel_row_t;

  class decoded_rows;
    logic [1:0]  fmt = FMT_BC1;
    texel_row_t  rows_due[$];
    int unsigned errors;
    int unsigned rows_checked;
    int unsigned blocks_by_fmt[4];

    function void set_format(logic [1:0] f);
      fmt = f;
    endfunction

    function int pending();
      return rows_due.size();
    endfunction

    // 565 -> 888 by bit replication, packed B:G:R
    function logic [23:0] rgb888_of(logic [15:0] c);
      logic [4:0] r5;
      logic [5:0] g6;
      logic [4:0] b5;
      r5 = c[15:11];
      g6 = c[10:5];
      b5 = c[4:0];
      return {b5, b5[4:2], g6, g6[5:4], r5, r5[4:2]};
    endfunction

    function pal_t palette_of(logic [63:0] word, bit punch);
      logic [15:0] c0, c1;
      logic [23:0] e0, e1;
      int unsigned ch0, ch1;
      pal_t p;
      c0 = word[15:0];
      c1 = word[31:16];
      e0 = rgb888_of(c0);
      e1 = rgb888_of(c1);
      p[0] = {8'hFF, e0};
      p[1] = {8'hFF, e1};
      p[2] = '0;
      p[3] = '0;
      for (int k = 0; k < 3; k++) begin
        ch0 = e0[8*k +: 8];
        ch1 = e1[8*k +: 8];
        if (c0 > c1 || !punch) begin
          p[2][8*k +: 8] = 8'((2 * ch0 + ch1) / 3);
          p[3][8*k +: 8] = 8'((ch0 + 2 * ch1) / 3);
        end else begin
          p[2][8*k +: 8] = 8'((ch0 + ch1) / 2);
        end
      end
      p[2][31:24] = 8'hFF;
      // punch-through: entry 3 stays transparent black
      if (c0 > c1 || !punch) p[3][31:24] = 8'hFF;
      return p;
    endfunction

    function ramp_t alpha_ramp_of(logic [63:0] word);
      int unsigned a0, a1;
      ramp_t r;
      a0 = word[7:0];
      a1 = word[15:8];
      r[0] = word[7:0];
      r[1] = word[15:8];
      if (a0 > a1) begin
        for (int unsigned i = 1; i <= 6; i++) r[i+1] = 8'(((7 - i) * a0 + i * a1) / 7);
      end else begin
        for (int unsigned i = 1; i <= 4; i++) r[i+1] = 8'(((5 - i) * a0 + i * a1) / 5);
        r[6] = 8'd0;
        r[7] = 8'd255;
      end
      return r;
    endfunction

    function void note_block(logic [63:0] lo, logic [63:0] hi);
      pal_t       pal;
      ramp_t      ramp;
      logic [31:0] idx;
      texel_row_t r;
      texel_t     tx;
      int         t;
      blocks_by_fmt[fmt]++;
      pal  = palette_of(fmt == FMT_BC1 ? lo : hi, fmt == FMT_BC1);
      idx  = fmt == FMT_BC1 ? lo[63:32] : hi[63:32];
      ramp = alpha_ramp_of(lo);
      for (int row = 0; row < 4; row++) begin
        for (int col = 0; col < 4; col++) begin
          t  = row * 4 + col;
          tx = pal[idx[2*t +: 2]];
          case (fmt)
            FMT_BC1: ;
            FMT_BC2: tx[31:24] = {lo[4*t +: 4], lo[4*t +: 4]};
            FMT_BC3: tx[31:24] = ramp[lo[16 + 3*t +: 3]];
            default: tx = '0;
          endcase
          r.texels[col] = tx;
        end
        r.row_idx  = 2'(row);
        r.last_row = (row == 3);
        rows_due.push_back(r);
      end
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask

    task check_row(texel_row_t got);
      texel_row_t want;
      if (rows_due.size() == 0) begin
        report_mismatch($sformatf("row %0d arrived with no block outstanding", got.row_idx));
        return;
      end
      want = rows_due.pop_front();
      rows_checked++;
      for (int c = 0; c < 4; c++)
        if (got.texels[c] !== want.texels[c])
          report_mismatch($sformatf("row %0d col %0d: got %h want %h",
                                    want.row_idx, c, got.texels[c], want.texels[c]));
      if (got.row_idx !== want.row_idx)
        report_mismatch($sformatf("row_index: got %0d want %0d", got.row_idx, want.row_idx));
      if (got.last_row !== want.last_row)
        report_mismatch($sformatf("last_row on row %0d: got %b want %b",
                                  want.row_idx, got.last_row, want.last_row));
    endtask
  endclass

endpackage

// ----- bench/tb.sv -----
// Top-level bench for bc1_bc2_bc3_block_decoder: drives blocks and format writes,
// checks every decoded row. Depends on bcd_pkg, tb_texel_pkg and the decoder RTL.
module tb;
  import bcd_pkg::*;
  import tb_texel_pkg::*;

  localparam int HALF_PERIOD  = 2;
  localparam int RESET_CYCLES = 9;
  localparam int STALL_LIMIT  = 2000;  // cycles with no transaction on either side
  localparam int SETTLE       = 8;     // spare cycles after the final drain
  localparam int HOLD_CYCLES  = 80;    // long output back-pressure stretch
  localparam int SEG_ITEMS    = 24;
  localparam int N_SEG        = 12;
  localparam int N_CORNERS    = 20;

  typedef struct packed {
    logic [1:0]  fmt;
    logic [63:0] lo;
    logic [63:0] hi;
  } corner_blk_t;

  // Directed blocks. BC3 index field 0xFAC688 repeats indices 0..7, so every ramp
  // entry is hit; color index 0xE4 walks entries 0..3 across each row.
  localparam corner_blk_t CORNERS [N_CORNERS] = '{
    '{FMT_BC1, 64'h0, 64'h0},
    '{FMT_BC1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF},
    '{FMT_BC1, 64'hE4E4E4E4_0000_FFFF, 64'h0123_4567_89AB_CDEF},  // c0 > c1
    '{FMT_BC1, 64'hE4E4E4E4_FFFF_0000, 64'h0},                    // c0 < c1, punch
    '{FMT_BC1, 64'h1B1B1B1B_8410_8410, 64'h0},                    // c0 == c1
    '{FMT_BC1, 64'hE4E4E4E4_07E0_F81F, 64'hFFFF_FFFF_FFFF_FFFF},
    '{FMT_BC1, 64'hFFFFFFFF_0821_0820, 64'h0},                    // all transparent
    '{FMT_BC2, 64'h0123_4567_89AB_CDEF, 64'hE4E4E4E4_FFFF_0000},  // c0 < c1 still 4-color
    '{FMT_BC2, 64'hFEDC_BA98_7654_3210, 64'hE4E4E4E4_001F_F800},
    '{FMT_BC2, 64'h0, 64'h0},
    '{FMT_BC2, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF},
    '{FMT_BC3, 64'hFAC688FAC688_14C8, 64'hE4E4E4E4_FFFF_0000},    // 7-step ramp
    '{FMT_BC3, 64'hFAC688FAC688_C814, 64'h1B1B1B1B_0000_FFFF},    // 5-step + 0/255
    '{FMT_BC3, 64'hFAC688FAC688_8080, 64'hE4E4E4E4_8410_8410},    // a0 == a1
    '{FMT_BC3, 64'hFAC688FAC688_00FF, 64'hFFFF_FFFF_FFFF_FFFF},
    '{FMT_BC3, 64'hFAC688FAC688_FF00, 64'h0},
    '{FMT_BC3, 64'h0, 64'h0},
    '{FMT_BC3, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF},
    '{FMT_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF},
    '{FMT_UNUSED, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210}
  };

  // Format per random segment; every code appears under each idling pattern.
  localparam logic [1:0] SEG_FMT [N_SEG] = '{
    FMT_BC1, FMT_BC2, FMT_BC3, FMT_UNUSED,
    FMT_BC3, FMT_BC1, FMT_UNUSED, FMT_BC2,
    FMT_BC2, FMT_BC3, FMT_UNUSED, FMT_BC1
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_wr_data = FMT_BC1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] in_block_low = '0;
  logic [63:0] in_block_high = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_texel_col0, out_texel_col1, out_texel_col2, out_texel_col3;
  logic [1:0]  out_row_index;
  logic        out_last_row;
  texel_row_t  seen_row;

  // idle odds in percent, and the remaining cycles of a forced output hold
  int snd_idle = 21;
  int rcv_idle = 66;
  int hold_left = 0;
  int stall_count = 0;

  decoded_rows sb = new();

  bc1_bc2_bc3_block_decoder DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_block_low  (in_block_low),
    .in_block_high (in_block_high),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_texel_col0(out_texel_col0),
    .out_texel_col1(out_texel_col1),
    .out_texel_col2(out_texel_col2),
    .out_texel_col3(out_texel_col3),
    .out_row_index (out_row_index),
    .out_last_row  (out_last_row)
  );

  always #HALF_PERIOD clk = ~clk;

  assign seen_row = {out_texel_col3, out_texel_col2, out_texel_col1, out_texel_col0,
                     out_row_index, out_last_row};

  // Receiver: ready changes on the falling edge. A pending hold keeps it low
  // for a counted stretch so the pipeline backs up into in_ready.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  // Row monitor: a transaction on the out side is checked at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready)
      sb.check_row(seen_row);
  end

  // Watchdog: any transaction clears the count; a long silence ends the run.
  always @(posedge clk) begin
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
      stall_count = 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d rows outstanding",
               STALL_LIMIT, sb.pending());
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_count++;
    end
  end

  // One block: optional idle cycles, then valid held until the transaction.
  task automatic send_block(logic [63:0] lo, logic [63:0] hi);
    while ($urandom_range(99) < snd_idle) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_block_low  <= lo;
    in_block_high <= hi;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_block(lo, hi);
  endtask

  // Stop offering and wait for every predicted row to come out.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Format write; only called with the decoder empty.
  task automatic write_format(logic [1:0] f);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= f;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_format(f);
  endtask

  // Random block, biased now and then toward equal color or alpha endpoints
  // and toward all-zero / all-one index words.
  function automatic void random_block(output logic [63:0] lo, output logic [63:0] hi);
    lo = {$urandom, $urandom};
    hi = {$urandom, $urandom};
    case ($urandom_range(9))
      0: begin
        lo[31:16] = lo[15:0];
        hi[31:16] = hi[15:0];
      end
      1: lo[15:8] = lo[7:0];
      2: begin
        lo[63:32] = '1;
        hi[63:32] = '1;
      end
      3: begin
        lo[63:16] = '0;
        hi[63:32] = '0;
      end
      default: ;
    endcase
  endfunction

  initial begin
    logic [63:0] lo, hi;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed corners, grouped by format; reconfigure only when drained.
    for (int i = 0; i < N_CORNERS; i++) begin
      if (i == 0 || CORNERS[i].fmt != sb.fmt) begin
        drain();
        write_format(CORNERS[i].fmt);
      end
      send_block(CORNERS[i].lo, CORNERS[i].hi);
    end

    // Random segments: sender-light / receiver-heavy idling, then swapped, then none.
    for (int seg = 0; seg < N_SEG; seg++) begin
      drain();
      if (seg == 4) begin
        snd_idle = 66;
        rcv_idle = 21;
      end else if (seg == 8) begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      write_format(SEG_FMT[seg]);
      // with no idling, hold the output off while blocks keep coming so the
      // decoder fills and drops in_ready
      if (seg == 9) begin
        @(posedge clk);
        hold_left = HOLD_CYCLES;
      end
      for (int n = 0; n < SEG_ITEMS; n++) begin
        random_block(lo, hi);
        send_block(lo, hi);
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d blocks (BC1 %0d, BC2 %0d, BC3 %0d, unused code %0d), %0d rows",
             sb.blocks_by_fmt[0] + sb.blocks_by_fmt[1] + sb.blocks_by_fmt[2]
               + sb.blocks_by_fmt[3],
             sb.blocks_by_fmt[0], sb.blocks_by_fmt[1], sb.blocks_by_fmt[2],
             sb.blocks_by_fmt[3], sb.rows_checked);
    $display("directed corners, three idling patterns, %0d-cycle output hold, %0d errors",
             HOLD_CYCLES, sb.errors);
    if (sb.errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/bcd_pkg.sv
rtl/bcd_color_pal.sv
rtl/bcd_alpha_ramp.sv
rtl/bcd_row_sel.sv
rtl/bc1_bc2_bc3_block_decoder.sv
bench/tb_texel_pkg.sv
bench/tb.sv
